// File: design/rmcs_pkg.sv
// Shared constants, codes and types for the reflective marker counter with speed output.
// Used by the top level, the front end and the speed unit; depends on nothing.
`default_nettype none

package rmcs_pkg;

  // field widths fixed by the item layout
  localparam int LEVEL_W    = 20;
  localparam int MARGIN_W   = 16;
  localparam int MPR_W      = 8;
  localparam int STALL_W    = 32;
  localparam int OUT_TIME_W = 32;
  localparam int COUNT_W    = 32;
  localparam int SPEED_W    = 36;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 136;

  // defaults for the top-level parameters
  localparam int TIME_WIDTH_DEF  = 32;
  localparam int QUEUE_DEPTH_DEF = 2;

  // reset values of the configuration registers
  localparam logic [MPR_W-1:0]   MPR_RESET   = MPR_W'(1);
  localparam logic [STALL_W-1:0] STALL_RESET = STALL_W'(500000);

  // 360 deg * 100 centideg * 1e6 us/s
  localparam logic [SPEED_W-1:0] SPEED_NUM = 36'd36000000000;
  localparam int DIV_STEPS = SPEED_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int DEN_W     = MPR_W + SPEED_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_MARGIN    = 2'd1,
    REG_MPR       = 2'd2,
    REG_STALL     = 2'd3
  } rmcs_reg_e;

  typedef enum logic [0:0] {
    ACT_SAMPLE = 1'b0,
    ACT_CLEAR  = 1'b1
  } rmcs_action_e;

  // configuration seen by the front end
  typedef struct packed {
    logic [LEVEL_W-1:0]  level;
    logic [MARGIN_W-1:0] margin;
    logic [STALL_W-1:0]  stall;
  } rmcs_cfg_t;

endpackage

`default_nettype wire

// File: design/reflective_marker_counter_speed_core.sv
// Top level of the reflective marker counter with speed output.
// Depends on rmcs_pkg, rmcs_front, rmcs_fifo and rmcs_speed.
//
// Usage:
//   Slave stream (s_axis_*): one transaction per sensor event. tuser carries the
//   action (sample or clear), tdata carries now_us and charge_start_us.
//   Master stream (m_axis_*): exactly one result transaction per input, in order,
//   with discharge time, surface state, marker count, period and speed.
//   Configuration channel (cfg_*): register index and 32-bit data, always ready;
//   write only while the block is idle.
// Processing:
//   The front end updates the comparator, counter and period in the accept
//   cycle. The speed unit then fetches the snapshot from the queue, forms the
//   product markers_per_rev * period, runs the bit-serial divide and loads the
//   output register; it takes no new item until the output register has the result.
//   Zero-speed results skip the divide.
// Reset:
//   rst_ni clears the surface state to light, the counter, period and last
//   marker time to zero, sets markers_per_rev to 1 and stall time to 500000 us.
// Stalls:
//   A stalled receiver holds the output register; the speed unit finishes its
//   current item and waits, and the queue keeps accepting until it is full.
`default_nettype none

module reflective_marker_counter_speed_core #(
  parameter int TIME_WIDTH  = rmcs_pkg::TIME_WIDTH_DEF,
  parameter int QUEUE_DEPTH = rmcs_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // slave stream
  input  wire logic                                 s_axis_tvalid_i,
  output logic                                      s_axis_tready_o,
  input  wire logic [rmcs_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,  // now_us, charge_start_us
  input  wire logic [0:0]                           s_axis_tuser_i,  // action
  // master stream
  output logic                                      m_axis_tvalid_o,
  input  wire logic                                 m_axis_tready_i,
  // discharge_us, surface_dark, marker_count, period_us, speed_centideg_per_s, zero fill
  output logic [rmcs_pkg::OUT_TDATA_W-1:0]          m_axis_tdata_o,
  // configuration writes
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [rmcs_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [rmcs_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int EntW = rmcs_pkg::OUT_TIME_W + rmcs_pkg::COUNT_W + TIME_WIDTH + 1;
  localparam int CntLo = rmcs_pkg::OUT_TIME_W + 1;
  localparam int PadW = rmcs_pkg::OUT_TDATA_W - 2 * rmcs_pkg::OUT_TIME_W
                        - rmcs_pkg::COUNT_W - rmcs_pkg::SPEED_W - 1;

  // configuration registers
  logic [rmcs_pkg::LEVEL_W-1:0]  level_q;
  logic [rmcs_pkg::MARGIN_W-1:0] margin_q;
  logic [rmcs_pkg::MPR_W-1:0]    mpr_q;
  logic [rmcs_pkg::STALL_W-1:0]  stall_q;
  rmcs_pkg::rmcs_cfg_t           cfg;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q  <= '0;
      margin_q <= '0;
      mpr_q    <= rmcs_pkg::MPR_RESET;
      stall_q  <= rmcs_pkg::STALL_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (rmcs_pkg::rmcs_reg_e'(cfg_index_i))
        rmcs_pkg::REG_THRESHOLD: level_q  <= cfg_data_i[rmcs_pkg::LEVEL_W-1:0];
        rmcs_pkg::REG_MARGIN:    margin_q <= cfg_data_i[rmcs_pkg::MARGIN_W-1:0];
        rmcs_pkg::REG_MPR:       mpr_q    <= cfg_data_i[rmcs_pkg::MPR_W-1:0];
        rmcs_pkg::REG_STALL:     stall_q  <= cfg_data_i[rmcs_pkg::STALL_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.level  = level_q;
  assign cfg.margin = margin_q;
  assign cfg.stall  = stall_q;

  // front end -> queue
  logic                    push, full, pop, empty;
  logic [EntW-1:0]         entry_in, entry_out;
  rmcs_pkg::rmcs_action_e  action;

  assign action = rmcs_pkg::rmcs_action_e'(s_axis_tuser_i);

  rmcs_front #(.TIME_WIDTH(TIME_WIDTH)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .action_i   (action),
    .now_i      (s_axis_tdata_i[rmcs_pkg::OUT_TIME_W-1:0]),
    .start_i    (s_axis_tdata_i[rmcs_pkg::IN_TDATA_W-1:rmcs_pkg::OUT_TIME_W]),
    .cfg_i      (cfg),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (entry_in)
  );

  rmcs_fifo #(.WIDTH(EntW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (entry_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (entry_out),
    .empty_o (empty)
  );

  // speed unit and output register
  logic [rmcs_pkg::OUT_TIME_W-1:0] discharge, period;
  logic [rmcs_pkg::COUNT_W-1:0]    count;
  logic [rmcs_pkg::SPEED_W-1:0]    speed;
  logic                            dark;

  rmcs_speed #(.TIME_WIDTH(TIME_WIDTH)) u_speed (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .pop_o       (pop),
    .entry_i     (entry_out),
    .mpr_i       (mpr_q),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .discharge_o (discharge),
    .dark_o      (dark),
    .count_o     (count),
    .period_o    (period),
    .speed_o     (speed)
  );

  assign m_axis_tdata_o = {{PadW{1'b0}}, speed, period, count, dark, discharge};

  // a clear transaction must queue a zero marker count
  a_clear_zeroes_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && action == rmcs_pkg::ACT_CLEAR) |-> (entry_in[CntLo +: rmcs_pkg::COUNT_W] == '0))
    else $error("clear transaction queued a non-zero marker count");

  // no speed without a period
  a_speed_needs_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && period == '0) |-> (speed == '0))
    else $error("non-zero speed reported with zero period");

  // hold the result transaction while the receiver stalls
  a_out_held_while_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("result transaction changed while the receiver stalled");

endmodule

`default_nettype wire

// File: design/rmcs_fifo.sv
// Short first-in first-out queue between the front end and the speed unit.
// Depends on nothing; width and depth come from the instantiating module.
`default_nettype none

module rmcs_fifo #(
  parameter int WIDTH = 97,
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(DEPTH - 1)) r = '0;
    else                       r = p + PtrW'(1);
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
      if (do_push && !do_pop)      cnt_q <= cnt_q + CntW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

`default_nettype wire

// File: design/rmcs_front.sv
// Front end: accepts sample and clear transactions, runs the hysteresis comparator,
// the marker counter and the stall check, and queues a snapshot. Depends on rmcs_pkg.
`default_nettype none

module rmcs_front #(
  parameter int TIME_WIDTH = rmcs_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire rmcs_pkg::rmcs_action_e              action_i,
  input  wire logic [rmcs_pkg::OUT_TIME_W-1:0]     now_i,
  input  wire logic [rmcs_pkg::OUT_TIME_W-1:0]     start_i,
  input  wire rmcs_pkg::rmcs_cfg_t                 cfg_i,
  input  wire logic                                full_i,
  output logic                                     push_o,
  // snapshot, lowest bits first: discharge 32, dark 1, count 32, period TIME_WIDTH
  output logic [rmcs_pkg::OUT_TIME_W+rmcs_pkg::COUNT_W+TIME_WIDTH:0] entry_o
);

  localparam int InW  = (TIME_WIDTH < rmcs_pkg::OUT_TIME_W) ? TIME_WIDTH : rmcs_pkg::OUT_TIME_W;
  localparam int CmpW = (TIME_WIDTH > rmcs_pkg::STALL_W) ? TIME_WIDTH : rmcs_pkg::STALL_W;

  logic                           dark_q, dark_d;
  logic [rmcs_pkg::COUNT_W-1:0]   total_q, total_d;
  logic [TIME_WIDTH-1:0]          last_q, last_d;
  logic [TIME_WIDTH-1:0]          period_q, period_d;

  logic [TIME_WIDTH-1:0]          now_t, start_t, disch, since_last, elapsed;
  logic [rmcs_pkg::LEVEL_W:0]     upper;
  logic [rmcs_pkg::LEVEL_W-1:0]   margin_x, lower;
  logic                           accept, is_clear, go_dark, go_light, stalled;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept;
  assign is_clear   = (action_i == rmcs_pkg::ACT_CLEAR);

  assign now_t      = TIME_WIDTH'(now_i[InW-1:0]);
  assign start_t    = TIME_WIDTH'(start_i[InW-1:0]);
  assign disch      = now_t - start_t;

  // thresholds: upper never overflows, lower is only used when it stays above zero
  assign margin_x   = rmcs_pkg::LEVEL_W'(cfg_i.margin);
  assign upper      = {1'b0, cfg_i.level} + (rmcs_pkg::LEVEL_W + 1)'(cfg_i.margin);
  assign lower      = cfg_i.level - margin_x;
  assign go_dark    = !dark_q && (CmpW'(disch) > CmpW'(upper));
  assign go_light   = dark_q && (cfg_i.level > margin_x) && (CmpW'(disch) < CmpW'(lower));

  // a new marker moves the reference to now, so no time has elapsed
  assign since_last = now_t - last_q;
  assign elapsed    = go_dark ? '0 : since_last;
  assign stalled    = (CmpW'(elapsed) >= CmpW'(cfg_i.stall));

  always_comb begin
    dark_d   = dark_q;
    total_d  = total_q;
    last_d   = last_q;
    period_d = period_q;
    if (is_clear) begin
      total_d = '0;
    end else begin
      if (go_dark) begin
        dark_d   = 1'b1;
        total_d  = total_q + rmcs_pkg::COUNT_W'(1);
        last_d   = now_t;
        period_d = since_last;
      end else if (go_light) begin
        dark_d = 1'b0;
      end
      if (stalled) period_d = '0;
    end
  end

  logic [TIME_WIDTH-1:0] disch_q, disch_d;
  assign disch_d = is_clear ? disch_q : disch;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dark_q   <= 1'b0;
      total_q  <= '0;
      last_q   <= '0;
      period_q <= '0;
      disch_q  <= '0;
    end else if (accept) begin
      dark_q   <= dark_d;
      total_q  <= total_d;
      last_q   <= last_d;
      period_q <= period_d;
      disch_q  <= disch_d;
    end
  end

  assign entry_o = {period_d, total_d, dark_d,
                    rmcs_pkg::OUT_TIME_W'(disch_d[InW-1:0])};

endmodule

`default_nettype wire

// File: design/rmcs_speed.sv
// Back end: takes snapshots from the queue, forms markers_per_rev * period and
// divides it into the speed constant one quotient bit a cycle. Depends on rmcs_pkg.
`default_nettype none

module rmcs_speed #(
  parameter int TIME_WIDTH = rmcs_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                empty_i,
  output logic                                     pop_o,
  input  wire logic [rmcs_pkg::OUT_TIME_W+rmcs_pkg::COUNT_W+TIME_WIDTH:0] entry_i,
  input  wire logic [rmcs_pkg::MPR_W-1:0]          mpr_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [rmcs_pkg::OUT_TIME_W-1:0]          discharge_o,
  output logic                                     dark_o,
  output logic [rmcs_pkg::COUNT_W-1:0]             count_o,
  output logic [rmcs_pkg::OUT_TIME_W-1:0]          period_o,
  output logic [rmcs_pkg::SPEED_W-1:0]             speed_o
);

  localparam int EntW = rmcs_pkg::OUT_TIME_W + rmcs_pkg::COUNT_W + TIME_WIDTH + 1;
  localparam int PerLo = rmcs_pkg::OUT_TIME_W + rmcs_pkg::COUNT_W + 1;
  localparam int PW   = (TIME_WIDTH > rmcs_pkg::SPEED_W) ? TIME_WIDTH : rmcs_pkg::SPEED_W;
  localparam int InW  = (TIME_WIDTH < rmcs_pkg::OUT_TIME_W) ? TIME_WIDTH : rmcs_pkg::OUT_TIME_W;
  localparam int DW   = rmcs_pkg::DEN_W;
  localparam int SW   = rmcs_pkg::SPEED_W;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_DONE} state_e;

  state_e                          state_q;
  logic                            out_valid_q;
  logic [rmcs_pkg::DIV_CNT_W-1:0]  cnt_q;

  logic [EntW-1:0]                 ent_q;
  logic [DW-1:0]                   den_q, rem_q;
  logic [SW-1:0]                   num_q, quo_q;

  logic [TIME_WIDTH-1:0]           period;
  logic [PW-1:0]                   period_ext;
  logic                            zero_speed, out_free, ge;
  logic [DW:0]                     shifted, diff;

  assign period     = ent_q[PerLo +: TIME_WIDTH];
  assign period_ext = PW'(period);
  assign zero_speed = (period == '0) || (mpr_i == '0) ||
                      (period_ext > PW'(rmcs_pkg::SPEED_NUM));
  assign out_free   = !out_valid_q || out_ready_i;
  assign pop_o      = (state_q == S_IDLE) && !empty_i;

  // restoring division step
  assign shifted    = {rem_q, num_q[SW-1]};
  assign diff       = shifted - {1'b0, den_q};
  assign ge         = (shifted >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i)              out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (!empty_i) state_q <= S_MUL;
        end
        S_MUL: begin
          cnt_q   <= rmcs_pkg::DIV_CNT_W'(rmcs_pkg::DIV_STEPS - 1);
          state_q <= zero_speed ? S_DONE : S_DIV;
        end
        S_DIV: begin
          cnt_q <= cnt_q - rmcs_pkg::DIV_CNT_W'(1);
          if (cnt_q == '0) state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) ent_q <= entry_i;
    if (state_q == S_MUL) begin
      den_q <= DW'(mpr_i) * DW'(period_ext[SW-1:0]);
      num_q <= rmcs_pkg::SPEED_NUM;
      rem_q <= '0;
      quo_q <= '0;
    end
    if (state_q == S_DIV) begin
      rem_q <= ge ? diff[DW-1:0] : shifted[DW-1:0];
      num_q <= {num_q[SW-2:0], 1'b0};
      quo_q <= {quo_q[SW-2:0], ge};
    end
    if (state_q == S_DONE && out_free) begin
      discharge_o <= ent_q[rmcs_pkg::OUT_TIME_W-1:0];
      dark_o      <= ent_q[rmcs_pkg::OUT_TIME_W];
      count_o     <= ent_q[rmcs_pkg::OUT_TIME_W+1 +: rmcs_pkg::COUNT_W];
      period_o    <= rmcs_pkg::OUT_TIME_W'(period[InW-1:0]);
      speed_o     <= quo_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: verif/tb.sv
// Self-checking testbench for reflective_marker_counter_speed_core.
// Depends on rmcs_pkg and the core; drives both streams and the register channel,
// predicts every result and compares it field by field.
`timescale 1ns / 100ps

module tb;
  import rmcs_pkg::*;

  localparam logic [63:0] CENTIDEG_NUM = 64'd36000000000;
  localparam int RAND_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 105;
  localparam int HOLD_AFTER = 60;    // results seen before the long receiver hold
  localparam int HOLD_CYCLES = 600;

  typedef struct {
    logic [31:0] discharge;
    logic        dark;
    logic [31:0] count;
    logic [31:0] period;
    logic [35:0] speed;
  } reading_t;

  typedef struct {
    bit       known;
    reading_t res;
  } typed_tag_t;

  typedef struct {
    bit           is_cfg;
    rmcs_reg_e    idx;
    logic [31:0]  val;
    rmcs_action_e act;
    logic [31:0]  now;
    logic [31:0]  start;
    bit           known;
    reading_t     res;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic s_axis_tvalid_i;
  logic s_axis_tready_o;
  logic [IN_TDATA_W-1:0] s_axis_tdata_i;   // now_us, charge_start_us
  logic [0:0] s_axis_tuser_i;              // action
  logic m_axis_tvalid_o;
  logic m_axis_tready_i;
  // discharge_us, surface_dark, marker_count, period_us, speed_centideg_per_s, zero fill
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  reflective_marker_counter_speed_core dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor copy of configuration and state
  logic [19:0] thr_level;
  logic [15:0] hyst_margin;
  logic [7:0]  mark_per_rev;
  logic [31:0] stall_us;
  logic        surf_dark;
  logic [31:0] mark_total;
  logic [31:0] mark_time;
  logic [31:0] mark_period;
  logic [31:0] last_dis;

  reading_t   due_readings[$];
  typed_tag_t typed_q[$];
  plan_row_t  plan_q[$];
  int err_cnt = 0;
  int results_seen = 0;
  int gap_mode = 1;

  function automatic void reset_marker_model();
    thr_level = '0;
    hyst_margin = '0;
    mark_per_rev = 8'd1;
    stall_us = 32'd500000;
    surf_dark = 1'b0;
    mark_total = '0;
    mark_time = '0;
    mark_period = '0;
    last_dis = '0;
  endfunction

  // Advance the hysteresis comparator, marker counter and period for one item.
  function automatic reading_t advance_marker(rmcs_action_e act, logic [31:0] now,
                                              logic [31:0] start);
    reading_t r;
    logic [31:0] d;
    logic [32:0] upper;
    logic [63:0] den;
    if (act == ACT_CLEAR) begin
      mark_total = '0;
    end else begin
      d = now - start;
      last_dis = d;
      upper = 33'(thr_level) + 33'(hyst_margin);
      if (!surf_dark) begin
        if ({1'b0, d} > upper) begin
          surf_dark = 1'b1;
          mark_total = mark_total + 32'd1;
          mark_period = now - mark_time;
          mark_time = now;
        end
      end else if (32'(thr_level) > 32'(hyst_margin) &&
                   d < 32'(thr_level) - 32'(hyst_margin)) begin
        surf_dark = 1'b0;
      end
      // stall check runs after the comparator on every sample
      if (now - mark_time >= stall_us) mark_period = '0;
    end
    r.discharge = last_dis;
    r.dark = surf_dark;
    r.count = mark_total;
    r.period = mark_period;
    den = 64'(mark_per_rev) * 64'(mark_period);
    r.speed = (den == 0) ? '0 : 36'(CENTIDEG_NUM / den);
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endfunction

  // Monitor: register writes, accepted samples and accepted results, all on pre-edge values.
  always @(posedge clk_i) begin
    reading_t pred;
    reading_t got;
    typed_tag_t tag;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (rmcs_reg_e'(cfg_index_i))
          REG_THRESHOLD: thr_level = cfg_data_i[19:0];
          REG_MARGIN:    hyst_margin = cfg_data_i[15:0];
          REG_MPR:       mark_per_rev = cfg_data_i[7:0];
          REG_STALL:     stall_us = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        pred = advance_marker(rmcs_action_e'(s_axis_tuser_i[0]), s_axis_tdata_i[31:0],
                              s_axis_tdata_i[63:32]);
        tag.known = 1'b0;
        if (typed_q.size() != 0) tag = typed_q.pop_front();
        // directed rows with a hand-typed reading take that one instead
        due_readings.push_back(tag.known ? tag.res : pred);
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        results_seen++;
        got.discharge = m_axis_tdata_o[31:0];
        got.dark = m_axis_tdata_o[32];
        got.count = m_axis_tdata_o[64:33];
        got.period = m_axis_tdata_o[96:65];
        got.speed = m_axis_tdata_o[132:97];
        if (due_readings.size() == 0) begin
          $error("unexpected result transaction, tdata %h", m_axis_tdata_o);
          err_cnt++;
        end else begin
          pred = due_readings.pop_front();
          check_field("discharge_us", 64'(pred.discharge), 64'(got.discharge));
          check_field("surface_dark", 64'(pred.dark), 64'(got.dark));
          check_field("marker_count", 64'(pred.count), 64'(got.count));
          check_field("period_us", 64'(pred.period), 64'(got.period));
          check_field("speed_centideg_per_s", 64'(pred.speed), 64'(got.speed));
          check_field("zero fill", 64'd0, 64'(m_axis_tdata_o[135:133]));
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (gap_mode == 0 || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Offer one sample; return at the edge that accepts it, tvalid still high.
  task automatic send_item(rmcs_action_e act, logic [31:0] now, logic [31:0] start,
                           bit known, reading_t res);
    int gap;
    typed_tag_t tag;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    tag.known = known;
    tag.res = res;
    typed_q.push_back(tag);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {start, now};
    s_axis_tuser_i <= act;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // Drop tvalid and hold until every outstanding reading has come back.
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (due_readings.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(rmcs_reg_e idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic plan_row_t blank_row();
    plan_row_t p;
    p.is_cfg = 1'b0;
    p.idx = REG_THRESHOLD;
    p.val = '0;
    p.act = ACT_SAMPLE;
    p.now = '0;
    p.start = '0;
    p.known = 1'b0;
    p.res = '{default: '0};
    return p;
  endfunction

  function automatic void row_cfg(rmcs_reg_e idx, logic [31:0] val);
    plan_row_t p;
    p = blank_row();
    p.is_cfg = 1'b1;
    p.idx = idx;
    p.val = val;
    plan_q.push_back(p);
  endfunction

  function automatic void row_item(rmcs_action_e act, logic [31:0] now, logic [31:0] start);
    plan_row_t p;
    p = blank_row();
    p.act = act;
    p.now = now;
    p.start = start;
    plan_q.push_back(p);
  endfunction

  function automatic void row_known(rmcs_action_e act, logic [31:0] now, logic [31:0] start,
                                    logic [31:0] dis, logic dark, logic [31:0] cnt,
                                    logic [31:0] per, logic [35:0] spd);
    plan_row_t p;
    p = blank_row();
    p.act = act;
    p.now = now;
    p.start = start;
    p.known = 1'b1;
    p.res.discharge = dis;
    p.res.dark = dark;
    p.res.count = cnt;
    p.res.period = per;
    p.res.speed = spd;
    plan_q.push_back(p);
  endfunction

  // Receiver: random stalls, long ready stretches, and one long hold to back up the input.
  initial begin
    int n;
    bit held;
    held = 1'b0;
    m_axis_tready_i <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        n = HOLD_CYCLES;
      end else begin
        n = $urandom_range(0, 99);
        n = (n < 30) ? 0 : (n < 85) ? $urandom_range(1, 4) : $urandom_range(20, 60);
      end
      if (n > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
      repeat (n) @(posedge clk_i);
    end
  end

  // Stimulus: directed table first, then random phases, each with a fresh register set.
  initial begin
    plan_row_t p;
    reading_t none;
    logic [31:0] lvl, mrg, mpr, stl, tbase, nowv, startv, dd, upper, lower;
    rmcs_action_e act;
    int r;

    none = '{default: '0};
    reset_marker_model();
    rst_ni <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i <= '0;
    s_axis_tuser_i <= ACT_SAMPLE;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= REG_THRESHOLD;
    cfg_data_i <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: level 0, margin 0, one marker per rev, stall 500000
    row_known(ACT_CLEAR, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 0, 0, 0);
    row_known(ACT_SAMPLE, 100, 100, 0, 0, 0, 0, 0);
    row_known(ACT_SAMPLE, 1000, 0, 1000, 1, 1, 1000, 36000000);
    // lower threshold clamps at zero, so dark holds
    row_known(ACT_SAMPLE, 2000, 2000, 0, 1, 1, 1000, 36000000);
    // widest discharge time; stall zeroes the period
    row_known(ACT_SAMPLE, 32'hFFFFFFFF, 0, 32'hFFFFFFFF, 1, 1, 0, 0);
    // clear touches only the counter
    row_known(ACT_CLEAR, 0, 0, 32'hFFFFFFFF, 1, 0, 0, 0);

    // band 400..600, stall 10000: boundaries, period of one, exact stall
    row_cfg(REG_THRESHOLD, 500);
    row_cfg(REG_MARGIN, 100);
    row_cfg(REG_MPR, 1);
    row_cfg(REG_STALL, 10000);
    row_item(ACT_SAMPLE, 5000, 5000);
    row_item(ACT_SAMPLE, 5600, 5000);
    row_item(ACT_SAMPLE, 6001, 5400);
    row_item(ACT_SAMPLE, 6400, 6000);
    row_item(ACT_SAMPLE, 0, 0);
    row_item(ACT_SAMPLE, 6002, 0);
    row_item(ACT_SAMPLE, 16001, 16002);
    row_item(ACT_SAMPLE, 16002, 16002);
    row_item(ACT_CLEAR, 32'hFFFFFFFF, 32'hFFFFFFFF);
    row_item(ACT_SAMPLE, 32'hFFFFFFFF, 0);

    // every register at its top value
    row_cfg(REG_THRESHOLD, 32'h000FFFFF);
    row_cfg(REG_MARGIN, 32'h0000FFFF);
    row_cfg(REG_MPR, 255);
    row_cfg(REG_STALL, 32'hFFFFFFFF);
    row_item(ACT_SAMPLE, 2000000, 1016961);
    row_item(ACT_SAMPLE, 2000000, 885890);
    row_item(ACT_SAMPLE, 3000000, 1885889);
    row_item(ACT_SAMPLE, 2999999, 2999999);

    for (int i = 0; i < plan_q.size(); i++) begin
      p = plan_q[i];
      if (p.is_cfg) begin
        drain_results();
        write_reg(p.idx, p.val);
      end else begin
        send_item(p.act, p.now, p.start, p.known, p.res);
      end
    end

    tbase = $urandom;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain_results();
      case ($urandom_range(0, 9))
        0: lvl = $urandom_range(0, 32'h000FFFFF);
        1, 2, 3, 4: lvl = $urandom_range(0, 2000);
        default: lvl = $urandom_range(0, 100000);
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2: mrg = $urandom_range(0, 50);
        8, 9: mrg = $urandom_range(0, 32'h0000FFFF);
        default: mrg = $urandom_range(0, 1000);
      endcase
      mpr = $urandom_range(1, 255);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: stl = $urandom_range(1, 5000);
        8: stl = $urandom_range(1, 32'hFFFFFFFF);
        9: stl = 500000;
        default: stl = $urandom_range(5000, 1000000);
      endcase
      write_reg(REG_THRESHOLD, lvl);
      write_reg(REG_MARGIN, mrg);
      write_reg(REG_MPR, mpr);
      write_reg(REG_STALL, stl);
      gap_mode = $urandom_range(0, 3);
      upper = lvl + mrg;
      lower = (lvl > mrg) ? lvl - mrg : 0;

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // advance the clock of the sensor, now and then by a stall-sized jump
        r = $urandom_range(0, 99);
        tbase += (r < 90) ? $urandom_range(1, 3000) :
                 (r < 98) ? $urandom_range(3000, 200000) : $urandom;
        nowv = tbase;
        act = ACT_SAMPLE;
        r = $urandom_range(0, 99);
        if (r < 5) begin
          act = ACT_CLEAR;
          nowv = $urandom;
          dd = $urandom;
        end else if (r < 10) begin
          nowv = $urandom;
          dd = $urandom;
        end else if (r < 40) begin
          dd = (lower > 0) ? $urandom_range(0, lower - 1) : 0;
        end else if (r < 70) begin
          dd = ($urandom_range(0, 9) == 0) ? $urandom_range(upper + 1, 32'hFFFFFFFF) :
               upper + 1 + $urandom_range(0, 5000);
        end else if (r < 85) begin
          case ($urandom_range(0, 3))
            0: dd = upper;
            1: dd = upper + 1;
            2: dd = lower;
            default: dd = (lower > 0) ? lower - 1 : 0;
          endcase
        end else begin
          dd = $urandom_range(lower, upper);
        end
        startv = (act == ACT_CLEAR) ? dd : nowv - dd;
        send_item(act, nowv, startv, 1'b0, none);
      end
    end

    drain_results();
    repeat (60) @(posedge clk_i);
    if (due_readings.size() != 0) begin
      $error("%0d expected results never arrived", due_readings.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Give up well past the slowest legal run.
  initial begin
    #(5_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: files.f
design/rmcs_pkg.sv
design/rmcs_fifo.sv
design/rmcs_front.sv
design/rmcs_speed.sv
design/reflective_marker_counter_speed_core.sv
verif/tb.sv
